// ===== rtl/sdtp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtp_pkg
// Types and character codes shared by the decimal text parser modules.
// ----------------------------------------------------------------------------
package sdtp_pkg;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int unsigned VALUE_W = 33;
    localparam int unsigned COUNT_W = 8;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_DIGITS,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] consumed;
    } t_result;

endpackage

// ===== rtl/sdtp_core.sv =====
// ----------------------------------------------------------------------------
// sdtp_core
// Parse state and combinational next-state logic: one character per enable.
// ----------------------------------------------------------------------------
module sdtp_core #(
    parameter int MAX_CHARS = 255
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_ch,
    input  logic             i_last,
    input  logic             i_unsigned_mode,
    output sdtp_pkg::t_result o_res
);
    import sdtp_pkg::*;

    localparam logic [COUNT_W-1:0] CHAR_LIMIT =
        (MAX_CHARS < 255) ? COUNT_W'(MAX_CHARS) : COUNT_W'(255);

    t_phase             r_phase, n_phase;
    logic [31:0]        r_acc, n_acc;
    logic               r_neg, n_neg;
    logic               r_sign, n_sign;
    logic [COUNT_W-1:0] r_cnt, n_cnt;

    logic [31:0]        b_acc;
    logic               b_neg, b_sign;
    logic [COUNT_W-1:0] b_cnt;
    logic [35:0]        prod;
    logic [31:0]        sat_acc;
    logic               is_digit, is_sign;

    // Value clamp at the end of a parse
    function automatic t_result finish(input logic [31:0] acc, input logic [COUNT_W-1:0] cnt,
                                       input logic sgn, input logic neg, input logic umode);
        t_result res;
        res.valid    = 1'b1;
        res.value    = '0;
        res.consumed = '0;
        if (cnt != COUNT_W'(sgn)) begin
            res.consumed = cnt;
            if (sgn && neg) begin
                res.value = acc[31] ? 33'h1_8000_0000 : 33'(~{1'b0, acc} + 33'd1);
            end else if (!sgn && umode) begin
                res.value = {1'b0, acc};
            end else begin
                res.value = acc[31] ? 33'h0_7FFF_FFFF : {1'b0, acc};
            end
        end
        return res;
    endfunction

    assign is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign is_sign  = (i_ch == CH_MINUS) || (i_ch == CH_PLUS);

    always_comb begin
        // A new window starts from a cleared accumulator
        if (r_phase == PH_FIRST) begin
            b_acc  = '0;
            b_neg  = 1'b0;
            b_sign = 1'b0;
            b_cnt  = '0;
        end else begin
            b_acc  = r_acc;
            b_neg  = r_neg;
            b_sign = r_sign;
            b_cnt  = r_cnt;
        end
        // x10 as shift and add
        prod    = {3'b0, b_acc, 1'b0} + {1'b0, b_acc, 3'b0} + {32'b0, i_ch[3:0] - CH_ZERO[3:0]};
        sat_acc = (|prod[35:32]) ? 32'hFFFF_FFFF : prod[31:0];
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_sign  = r_sign;
        n_cnt   = r_cnt;
        o_res   = '0;
        if (i_en) begin
            unique case (r_phase)
                PH_SKIP: begin
                    if (i_last) begin
                        n_phase = PH_FIRST;
                    end
                end
                PH_FIRST, PH_DIGITS: begin
                    n_acc   = b_acc;
                    n_neg   = b_neg;
                    n_sign  = b_sign;
                    n_cnt   = b_cnt;
                    n_phase = PH_DIGITS;
                    if (r_phase == PH_FIRST && !i_unsigned_mode && is_sign) begin
                        n_sign = 1'b1;
                        n_neg  = (i_ch == CH_MINUS);
                        n_cnt  = COUNT_W'(1);
                        if (i_last) begin
                            o_res   = finish('0, COUNT_W'(1), 1'b1, n_neg, i_unsigned_mode);
                            n_phase = PH_FIRST;
                        end
                    end else if (is_digit) begin
                        n_acc = sat_acc;
                        n_cnt = b_cnt + COUNT_W'(1);
                        if (i_last || n_cnt >= CHAR_LIMIT) begin
                            o_res   = finish(n_acc, n_cnt, b_sign, b_neg, i_unsigned_mode);
                            n_phase = i_last ? PH_FIRST : PH_SKIP;
                        end
                    end else begin
                        o_res   = finish(b_acc, b_cnt, b_sign, b_neg, i_unsigned_mode);
                        n_phase = i_last ? PH_FIRST : PH_SKIP;
                    end
                end
                default: begin
                    n_phase = PH_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_sign  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_sign  <= n_sign;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/saturating_decimal_text_parser_top.sv =====
// ----------------------------------------------------------------------------
// saturating_decimal_text_parser_top
// Parses a leading decimal number from a character stream, with saturation.
// ----------------------------------------------------------------------------
//  channel | direction | transaction
//  s       | in        | one character, tlast = last character of the window
//  m       | out       | parsed value and characters consumed
//  cfg     | in        | unsigned_mode write, taken whenever i_cfg_we is high
//
// One character per cycle; the parse step is a single shift-and-add x10
// with saturation, then the result register. A result appears in the cycle
// after the character that ends the parse. The input stalls only while a
// held result is not taken. Reset clears parse state and the mode.
// ----------------------------------------------------------------------------
module saturating_decimal_text_parser_top #(
    parameter int MAX_CHARS = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tlast,   // window_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [32:0] parsed_value, [40:33] consumed, rest zero
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata  // unsigned_mode
);
    import sdtp_pkg::*;

    logic               r_umode;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_value;
    logic [COUNT_W-1:0] r_consumed;
    logic               accept;
    t_result            res;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    sdtp_core #(
        .MAX_CHARS(MAX_CHARS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (accept),
        .i_ch           (i_s_tdata),
        .i_last         (i_s_tlast),
        .i_unsigned_mode(r_umode),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_umode     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_umode <= i_cfg_wdata;
            end
            if (accept && res.valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res.valid) begin
            r_value    <= res.value;
            r_consumed <= res.consumed;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_consumed, r_value};

endmodule
